// ===== rtl/well_plate_led_frame_controller_assert.svh =====
// Assertion macros for the well plate LED frame controller
`ifndef WELL_PLATE_LED_FRAME_CONTROLLER_ASSERT_SVH
`define WELL_PLATE_LED_FRAME_CONTROLLER_ASSERT_SVH

// check a property on the rising clock edge, off while reset is low
`define WPLFC_ASSERT(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) \
		else $error(msg);

// same check on the block's own clock and reset
`define WPLFC_ASSERT_CLK(lbl, prop, msg) \
	`WPLFC_ASSERT(lbl, clk, arst_n, prop, msg)

`endif

// ===== rtl/wplfc_pkg.sv =====
// Types and constants shared by the well plate LED frame controller
`default_nettype none
package wplfc_pkg;

	localparam int ROWS        = 8;
	localparam int COLUMNS     = 12;
	localparam int FRAME_W     = ROWS * COLUMNS;
	localparam int ROW_W       = $clog2(ROWS);
	localparam int ROW_IDX_W   = 5;
	localparam int COL_NUM_W   = 4;
	localparam int EXPOSURE_W  = 17;
	localparam logic [EXPOSURE_W-1:0] EXPOSURE_RESET = 17'd1000;

	typedef enum logic [3:0] {
		KIND_TICK       = 4'd0,
		KIND_CLEAR_ALL  = 4'd1,
		KIND_SET_COLUMN = 4'd2,
		KIND_SET_ROW    = 4'd3,
		KIND_SET_WELL   = 4'd4,
		KIND_CLEAR_ROW  = 4'd5,
		KIND_CLEAR_COL  = 4'd6,
		KIND_REFRESH    = 4'd7,
		KIND_SELF_TEST  = 4'd8,
		KIND_RESTART    = 4'd9,
		KIND_LOAD_MASK  = 4'd10
	} kind_t;

	typedef struct packed {
		kind_t                  kind;
		logic [ROW_IDX_W-1:0]   row_index;
		logic [COL_NUM_W-1:0]   column_number;
		logic [FRAME_W-1:0]     mask;
	} item_t;

	typedef struct packed {
		logic                   status;
		logic [FRAME_W-1:0]     frame;
		logic                   scanning;
		logic [ROW_W-1:0]       shown_row;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/well_plate_led_frame_controller.sv =====
// Top level of the well plate LED frame controller
// Keeps a 96-bit LED frame for an 8 by 12 well plate (bit row*12+col) and a row exposure
// scan; every command or tick word in yields exactly one result word out, carrying status,
// the frame after the command and the scan position. A word passes through an input
// register and then the result register before its result word is presented;
// one word per cycle is sustained while m_tready stays high; the combinational update of
// frame and scan state between them sets that rate. exposure_ms is written through
// cfg_wen/cfg_wdata, to be written only while the block is idle, which the block does not
// enforce; exposure_ms resets to 1000, and restart clears the frame and scan but keeps it.
`default_nettype none
module well_plate_led_frame_controller
	import wplfc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wen,
	input  wire logic [EXPOSURE_W-1:0] cfg_wdata,   // exposure_ms
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [111:0]          s_tdata,     // row_index, column_number, mask_low, mask_high
	input  wire logic [3:0]            s_tuser,     // kind
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [103:0]               m_tdata,     // frame_low, frame_high, scanning, shown_row
	output logic                       m_tuser      // status
);

	item_t   in_item;
	item_t   item;
	logic    item_valid;
	logic    item_ready;
	result_t res;

	assign in_item.kind          = kind_t'(s_tuser);
	assign in_item.row_index     = s_tdata[4:0];
	assign in_item.column_number = s_tdata[8:5];
	assign in_item.mask          = {s_tdata[104:73], s_tdata[72:9]};

	wplfc_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_item    (in_item),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	wplfc_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

	assign m_tdata = {4'b0000, res.shown_row, res.scanning, res.frame};
	assign m_tuser = res.status;

endmodule
`default_nettype wire

// ===== rtl/wplfc_in_reg.sv =====
// Input register stage of the well plate LED frame controller
`default_nettype none
module wplfc_in_reg
	import wplfc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire item_t in_item,
	output logic       item_valid,
	input  wire logic  item_ready,
	output item_t      item
);

	logic  valid_s1;
	item_t item_s1;

	assign in_ready   = !valid_s1 || item_ready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (item_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/wplfc_engine.sv =====
// Frame and scan state update with result register
`default_nettype none
`include "well_plate_led_frame_controller_assert.svh"
module wplfc_engine
	import wplfc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wen,
	input  wire logic [EXPOSURE_W-1:0] cfg_wdata,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire item_t                 item,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output result_t                    res
);

	logic [FRAME_W-1:0]    frame_q;
	logic                  scan_on_q;
	logic [ROW_W-1:0]      scan_row_q;
	logic [EXPOSURE_W-1:0] elapsed_q;
	logic [EXPOSURE_W-1:0] exposure_q;
	logic                  res_valid_q;
	result_t               res_q;

	logic [FRAME_W-1:0]    row_mask;
	logic [FRAME_W-1:0]    col_mask;
	logic [FRAME_W-1:0]    frame_n;
	logic                  scan_on_n;
	logic [ROW_W-1:0]      scan_row_n;
	logic [EXPOSURE_W-1:0] elapsed_n;
	logic [EXPOSURE_W-1:0] tick_sum;
	logic                  status_n;
	logic                  starts;
	logic                  adv;

	assign item_ready = !res_valid_q || res_ready;
	assign adv        = item_valid && item_ready;
	assign res_valid  = res_valid_q;
	assign res        = res_q;
	assign tick_sum   = elapsed_q + EXPOSURE_W'(1);

	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			for (int c = 0; c < COLUMNS; c++) begin
				row_mask[r*COLUMNS+c] = (item.row_index == ROW_IDX_W'(r));
				col_mask[r*COLUMNS+c] = (item.column_number == COL_NUM_W'(c + 1));
			end
		end
	end

	always_comb begin
		frame_n    = frame_q;
		scan_on_n  = scan_on_q;
		scan_row_n = scan_row_q;
		elapsed_n  = elapsed_q;
		status_n   = 1'b0;
		starts     = 1'b0;
		unique case (item.kind) inside
			KIND_TICK: begin
				if (scan_on_q) begin
					if (tick_sum >= exposure_q) begin
						elapsed_n = '0;
						if (scan_row_q == ROW_W'(ROWS - 1)) begin
							scan_on_n  = 1'b0;
							scan_row_n = '0;
							frame_n    = '0;
						end else begin
							scan_row_n = scan_row_q + ROW_W'(1);
						end
					end else begin
						elapsed_n = tick_sum;
					end
				end
			end
			KIND_CLEAR_ALL, KIND_SELF_TEST, KIND_RESTART: begin
				frame_n = '0;
			end
			KIND_SET_COLUMN: begin
				frame_n = frame_q | col_mask;
				starts  = 1'b1;
			end
			KIND_SET_ROW: begin
				frame_n = frame_q | row_mask;
				starts  = 1'b1;
			end
			KIND_SET_WELL: begin
				frame_n = frame_q | (row_mask & col_mask);
				starts  = 1'b1;
			end
			KIND_CLEAR_ROW: begin
				frame_n = frame_q & ~row_mask;
			end
			KIND_CLEAR_COL: begin
				frame_n = frame_q & ~col_mask;
			end
			KIND_REFRESH: begin
				frame_n = frame_q;
			end
			KIND_LOAD_MASK: begin
				frame_n = item.mask;
				starts  = 1'b1;
			end
			default: begin
				status_n = 1'b1;
			end
		endcase
		if (item.kind != KIND_TICK && !status_n) begin
			scan_on_n  = starts;
			scan_row_n = '0;
			elapsed_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exposure_q <= EXPOSURE_RESET;
		end else if (cfg_wen) begin
			exposure_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q    <= '0;
			scan_on_q  <= 1'b0;
			scan_row_q <= '0;
			elapsed_q  <= '0;
		end else if (adv) begin
			frame_q    <= frame_n;
			scan_on_q  <= scan_on_n;
			scan_row_q <= scan_row_n;
			elapsed_q  <= elapsed_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.status    <= status_n;
			res_q.frame     <= frame_n;
			res_q.scanning  <= scan_on_n;
			res_q.shown_row <= scan_on_n ? scan_row_n : '0;
		end
	end

	`WPLFC_ASSERT_CLK(a_row_idle, !scan_on_q |-> scan_row_q == '0, "scan row set while idle")
	`WPLFC_ASSERT_CLK(a_ticks_idle, !scan_on_q |-> elapsed_q == '0, "tick count set while idle")
	`WPLFC_ASSERT_CLK(a_err_hold, (adv && status_n) |=> frame_q == $past(frame_q), "frame changed on error")
	`WPLFC_ASSERT_CLK(a_shown_idle, (res_valid_q && !res_q.scanning) |-> res_q.shown_row == '0, "shown row set while idle")

endmodule
`default_nettype wire
